@@ rtl/core/lvcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Logarithmic variate chop-down package
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package lvcd_pkg;

    localparam int DEF_COUNT_BITS = 16;
    localparam int DEF_FRAC_BITS  = 32;

    localparam int VAL_W     = 32;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_THETA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PROB  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_INIT,
        S_DIV,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic div_init;
        logic div_step;
        logic update;
        logic set_cap;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic gt;
        logic at_limit;
        logic div_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/core/lvcd_datapath.sv @@
// ----------------------------------------------------------------------------
// Logarithmic variate chop-down datapath
// Configuration registers, sample and probability registers, count, the
// registered multiplier and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lvcd_datapath import lvcd_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [VAL_W-1:0]      i_cfg_data,
    input  wire logic [VAL_W-1:0]      i_sample,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic [COUNT_BITS-1:0]      o_count,
    output logic                       o_capped
);

    localparam logic [VAL_W-1:0] FRAC_MASK = (FRAC_BITS >= VAL_W) ? {VAL_W{1'b1}} :
        VAL_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [VAL_W-1:0]      r_theta;
    logic [VAL_W-1:0]      r_first;
    logic [VAL_W-1:0]      r_u;
    logic [VAL_W-1:0]      r_p;
    logic [COUNT_BITS-1:0] r_k;
    logic                  r_cap;
    logic [PROD_W-1:0]     r_prod;
    logic [VAL_W-1:0]      r_qval;
    logic [VAL_W-1:0]      r_q;
    logic [COUNT_BITS-1:0] r_rem;
    logic [STEP_W-1:0]     r_step;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_cap;

    logic [PROD_W-1:0]     prod_sh;
    logic [COUNT_BITS:0]   trial;
    logic                  trial_ge;
    logic [COUNT_BITS:0]   trial_diff;
    logic [VAL_W-1:0]      p_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theta <= '0;
            r_first <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SHAPE_THETA: r_theta <= i_cfg_data;
                REG_FIRST_PROB:  r_first <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign prod_sh    = r_prod >> FRAC_BITS;
    assign trial      = {r_rem, r_q[VAL_W-1]};
    assign trial_ge   = trial >= {1'b0, r_k};
    assign trial_diff = trial - {1'b0, r_k};
    assign p_next     = r_qval - r_q - VAL_W'(r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u   <= i_sample & FRAC_MASK;
            r_p   <= r_first & FRAC_MASK;
            r_k   <= COUNT_BITS'(1);
            r_cap <= 1'b0;
        end
        if (i_cmd.step) begin
            r_u    <= r_u - r_p;
            r_k    <= r_k + COUNT_BITS'(1);
            r_prod <= r_p * (r_theta & FRAC_MASK);
        end
        if (i_cmd.set_cap) begin
            r_k   <= COUNT_MAX;
            r_cap <= 1'b1;
        end
        if (i_cmd.div_init) begin
            r_qval <= prod_sh[VAL_W-1:0];
            r_q    <= prod_sh[VAL_W-1:0];
            r_rem  <= '0;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            r_q    <= {r_q[VAL_W-2:0], trial_ge};
            r_rem  <= trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.update) begin
            r_p <= p_next;
        end
        if (i_cmd.out_load) begin
            r_out_count <= r_k;
            r_out_cap   <= r_cap;
        end
    end

    assign o_stat.gt       = r_u > r_p;
    assign o_stat.at_limit = (r_k == COUNT_MAX) || (r_p == '0);
    assign o_stat.div_last = r_step == STEP_W'(DIV_STEPS - 1);
    assign o_count         = r_out_count;
    assign o_capped        = r_out_cap;

endmodule

`default_nettype wire

@@ rtl/core/lvcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Logarithmic variate chop-down controller
// Sequences the compare, step, multiply, divide and update phases and owns
// the stream handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lvcd_ctrl import lvcd_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.gt) begin
                    n_state = S_DONE;
                end else if (i_stat.at_limit) begin
                    o_cmd.set_cap = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/core/logarithmic_variate_chop_down_core.sv @@
// ----------------------------------------------------------------------------
// Logarithmic variate chop-down core
// Turns a Q0.32 uniform sample into a Logarithmic-distributed count by
// chop-down inversion.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[31:0] uniform_sample
//  m_axis    out        tdata[COUNT_BITS-1:0] variate_count, [COUNT_BITS] count_capped
//  cfg       in         idx 0 shape_theta, idx 1 first_prob
//
// For each count beyond the first, a sample passes through the compare, multiply,
// restoring divide and update steps.
// Reset is synchronous and clears the control state and both configuration registers.
// A new sample is accepted while a finished result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module logarithmic_variate_chop_down_core import lvcd_pkg::*; #(
    parameter int COUNT_BITS = DEF_COUNT_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int OUT_W      = ((COUNT_BITS + 1 + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [VAL_W-1:0]     i_cfg_data,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [31:0] uniform_sample
    input  wire logic [VAL_W-1:0]     i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // [COUNT_BITS-1:0] variate_count, [COUNT_BITS] count_capped, zero above
    output logic [OUT_W-1:0]          o_m_axis_tdata
);

    t_dp_cmd               cmd;
    t_dp_stat              stat;
    logic [COUNT_BITS-1:0] count;
    logic                  capped;

    lvcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lvcd_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_s_axis_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_count    (count),
        .o_capped   (capped)
    );

    always_comb begin
        o_m_axis_tdata                 = '0;
        o_m_axis_tdata[COUNT_BITS-1:0] = count;
        o_m_axis_tdata[COUNT_BITS]     = capped;
    end

endmodule

`default_nettype wire

@@ rtl/core/lvcd_checker.sv @@
// ----------------------------------------------------------------------------
// Logarithmic variate chop-down port checker
// Concurrent checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module lvcd_checker #(
    parameter int COUNT_BITS = 16,
    parameter int OUT_W      = 24
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_m_axis_tready,
    input wire logic             o_m_axis_tvalid,
    input wire logic [OUT_W-1:0] o_m_axis_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[COUNT_BITS-1:0] != '0)
        else $error("count below one");

    a_cap_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[COUNT_BITS] |->
            &o_m_axis_tdata[COUNT_BITS-1:0])
        else $error("capped result not at maximum count");

endmodule

bind logarithmic_variate_chop_down_core lvcd_checker #(
    .COUNT_BITS (COUNT_BITS),
    .OUT_W      (OUT_W)
) u_lvcd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
